// File: hw/rtl/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types, event codes, constants and digit helpers for the clock
// time-set controller.
// ----------------------------------------------------------------------------
package cts_pkg;

    localparam int CfgAddrW = 3;
    localparam int CfgDataW = 32;

    localparam logic [CfgAddrW-3:0] RegBlinkPeriod = 1'b0;

    localparam logic [7:0] BlinkPeriodReset = 8'd32;
    localparam logic [4:0] HourMax          = 5'd23;
    localparam logic [5:0] MinuteMax        = 6'd59;
    localparam logic [3:0] BlankDigit       = 4'd10;

    typedef enum logic [2:0] {
        ReqTick      = 3'd0,
        ReqModeClick = 3'd1,
        ReqModeLong  = 3'd2,
        ReqRelease   = 3'd3,
        ReqAdd       = 3'd4,
        ReqSub       = 3'd5
    } req_t;

    typedef struct packed {
        logic [2:0] req_type;
        logic [4:0] rtc_hour;
        logic [5:0] rtc_minute;
    } in_word_t;

    typedef struct packed {
        logic [3:0] hour_tens;
        logic [3:0] hour_ones;
        logic [3:0] minute_tens;
        logic [3:0] minute_ones;
        logic       dot_phase;
        logic       clock_write;
        logic [4:0] write_hour;
        logic [5:0] write_minute;
        logic       in_edit;
        logic       edit_minutes;
    } out_word_t;

    // tens digit of a value below 64
    function automatic logic [3:0] tens_of(input logic [5:0] v);
        logic [3:0] t;
        if (v >= 6'd60)      t = 4'd6;
        else if (v >= 6'd50) t = 4'd5;
        else if (v >= 6'd40) t = 4'd4;
        else if (v >= 6'd30) t = 4'd3;
        else if (v >= 6'd20) t = 4'd2;
        else if (v >= 6'd10) t = 4'd1;
        else                 t = 4'd0;
        return t;
    endfunction

    // ones digit of a value below 64
    function automatic logic [3:0] ones_of(input logic [5:0] v);
        logic [5:0] base;
        logic [5:0] diff;
        base = 6'd0;
        unique case (tens_of(v))
            4'd6:    base = 6'd60;
            4'd5:    base = 6'd50;
            4'd4:    base = 6'd40;
            4'd3:    base = 6'd30;
            4'd2:    base = 6'd20;
            4'd1:    base = 6'd10;
            default: base = 6'd0;
        endcase
        diff = v - base;
        return diff[3:0];
    endfunction

endpackage

// File: hw/rtl/cts_cfg_regs.sv
// ----------------------------------------------------------------------------
// cts_cfg_regs
// APB-style configuration register file holding the blink period.
// ----------------------------------------------------------------------------
module cts_cfg_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cts_pkg::CfgAddrW-1:0]  paddr,
    input  logic [cts_pkg::CfgDataW-1:0]  pwdata,
    output logic [cts_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready,
    output logic [7:0]                    blink_period
);

    logic [7:0] blink_period_reg;
    logic [7:0] blink_period_next;
    logic       sel_period;

    assign pready     = 1'b1;
    assign sel_period = (paddr[cts_pkg::CfgAddrW-1:2] == cts_pkg::RegBlinkPeriod);

    always_comb
    begin
        blink_period_next = blink_period_reg;
        if (psel && penable && pwrite && sel_period)
        begin
            blink_period_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blink_period_reg <= cts_pkg::BlinkPeriodReset;
        end
        else
        begin
            blink_period_reg <= blink_period_next;
        end
    end

    assign prdata       = sel_period ? {{(cts_pkg::CfgDataW-8){1'b0}}, blink_period_reg}
                                     : '0;
    assign blink_period = blink_period_reg;

endmodule

// File: hw/rtl/cts_core.sv
// ----------------------------------------------------------------------------
// cts_core
// Mode, edit and blink state with the single-pass event update and the
// display digit formatting of each result word.
// ----------------------------------------------------------------------------
module cts_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  cts_pkg::in_word_t  ev,
    input  logic [7:0]         blink_period,
    output cts_pkg::out_word_t res
);

    logic       edit_mode_reg,   edit_mode_next;
    logic       edit_unit_reg,   edit_unit_next;
    logic [4:0] held_hour_reg,   held_hour_next;
    logic [5:0] held_minute_reg, held_minute_next;
    logic       latch_reg,       latch_next;
    logic [7:0] blink_count_reg, blink_count_next;
    logic       blink_phase_reg, blink_phase_next;

    logic       wr;
    logic [4:0] wh;
    logic [5:0] wm;
    logic [8:0] cnt;
    logic       blank_h;
    logic       blank_m;

    assign cnt = {1'b0, blink_count_reg} + 9'd1;

    always_comb
    begin
        edit_mode_next   = edit_mode_reg;
        edit_unit_next   = edit_unit_reg;
        held_hour_next   = held_hour_reg;
        held_minute_next = held_minute_reg;
        latch_next       = latch_reg;
        blink_count_next = blink_count_reg;
        blink_phase_next = blink_phase_reg;
        wr               = 1'b0;
        wh               = '0;
        wm               = '0;
        unique case (ev.req_type)
            cts_pkg::ReqTick:
            begin
                if (!edit_mode_reg)
                begin
                    held_hour_next   = (ev.rtc_hour > cts_pkg::HourMax)
                                       ? cts_pkg::HourMax : ev.rtc_hour;
                    held_minute_next = (ev.rtc_minute > cts_pkg::MinuteMax)
                                       ? cts_pkg::MinuteMax : ev.rtc_minute;
                end
                if (cnt > {1'b0, blink_period})
                begin
                    blink_phase_next = ~blink_phase_reg;
                    blink_count_next = '0;
                end
                else
                begin
                    blink_count_next = cnt[7:0];
                end
            end
            cts_pkg::ReqModeClick:
            begin
                if (edit_mode_reg)
                begin
                    edit_unit_next = ~edit_unit_reg;
                end
            end
            cts_pkg::ReqModeLong:
            begin
                if (!latch_reg)
                begin
                    latch_next     = 1'b1;
                    edit_mode_next = ~edit_mode_reg;
                    if (edit_mode_reg)
                    begin
                        wr = 1'b1;
                        wh = held_hour_reg;
                        wm = held_minute_reg;
                    end
                end
            end
            cts_pkg::ReqRelease:
            begin
                latch_next = 1'b0;
            end
            cts_pkg::ReqAdd:
            begin
                if (edit_mode_reg && !edit_unit_reg)
                begin
                    held_hour_next = (held_hour_reg >= cts_pkg::HourMax)
                                     ? 5'd0 : held_hour_reg + 5'd1;
                end
                else if (edit_mode_reg)
                begin
                    held_minute_next = (held_minute_reg >= cts_pkg::MinuteMax)
                                       ? 6'd0 : held_minute_reg + 6'd1;
                end
            end
            cts_pkg::ReqSub:
            begin
                if (edit_mode_reg && !edit_unit_reg)
                begin
                    held_hour_next = (held_hour_reg == 5'd0)
                                     ? cts_pkg::HourMax : held_hour_reg - 5'd1;
                end
                else if (edit_mode_reg)
                begin
                    held_minute_next = (held_minute_reg == 6'd0)
                                       ? cts_pkg::MinuteMax : held_minute_reg - 6'd1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            edit_mode_reg   <= 1'b0;
            edit_unit_reg   <= 1'b0;
            held_hour_reg   <= '0;
            held_minute_reg <= '0;
            latch_reg       <= 1'b0;
            blink_count_reg <= '0;
            blink_phase_reg <= 1'b0;
        end
        else if (step)
        begin
            edit_mode_reg   <= edit_mode_next;
            edit_unit_reg   <= edit_unit_next;
            held_hour_reg   <= held_hour_next;
            held_minute_reg <= held_minute_next;
            latch_reg       <= latch_next;
            blink_count_reg <= blink_count_next;
            blink_phase_reg <= blink_phase_next;
        end
    end

    assign blank_h = !blink_phase_next && edit_mode_next && !edit_unit_next;
    assign blank_m = !blink_phase_next && edit_mode_next && edit_unit_next;

    always_comb
    begin
        res.hour_tens    = blank_h ? cts_pkg::BlankDigit
                                   : cts_pkg::tens_of({1'b0, held_hour_next});
        res.hour_ones    = blank_h ? cts_pkg::BlankDigit
                                   : cts_pkg::ones_of({1'b0, held_hour_next});
        res.minute_tens  = blank_m ? cts_pkg::BlankDigit : cts_pkg::tens_of(held_minute_next);
        res.minute_ones  = blank_m ? cts_pkg::BlankDigit : cts_pkg::ones_of(held_minute_next);
        res.dot_phase    = blink_phase_next;
        res.clock_write  = wr;
        res.write_hour   = wh;
        res.write_minute = wm;
        res.in_edit      = edit_mode_next;
        res.edit_minutes = edit_unit_next;
    end

endmodule

// File: hw/rtl/clock_time_set_controller.sv
// ----------------------------------------------------------------------------
// clock_time_set_controller
// Hour:minute clock setting controller with blinking edit display.
// ----------------------------------------------------------------------------
// usage
//   in_valid/in_ready carry one event word (tick with clock time, mode
//   click, long press, release, add, subtract); out_valid/out_ready carry
//   one result word per event: four display digits (10 = blank), the dot
//   phase, an optional clock write and the mode flags.
//   the blink period is set over the apb port at address 0, reset 32.
//   an accepted event sits in the input register, then the event update
//   and digit formatting run in one pass into the result register.
//   throughput is one event per cycle while the receiver takes results;
//   the state update loop in the core sets that rate.
//   a stalled receiver holds the result word; one more event waits in the
//   input register, after which in_ready drops until out_ready returns.
//   reset empties both registers, clears all mode and blink state, and
//   loads the blink period with 32.
// ----------------------------------------------------------------------------
module clock_time_set_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  cts_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_ready,
    output cts_pkg::out_word_t            out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [cts_pkg::CfgAddrW-1:0]  paddr,
    input  logic [cts_pkg::CfgDataW-1:0]  pwdata,
    output logic [cts_pkg::CfgDataW-1:0]  prdata,
    output logic                          pready
);

    logic               s1_valid_reg,  s1_valid_next;
    cts_pkg::in_word_t  s1_word_reg;
    logic               out_valid_reg, out_valid_next;
    cts_pkg::out_word_t out_word_reg;
    cts_pkg::out_word_t res;
    logic               step;
    logic               in_acc;
    logic [7:0]         blink_period;

    cts_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .blink_period (blink_period)
    );

    cts_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .ev           (s1_word_reg),
        .blink_period (blink_period),
        .res          (res)
    );

    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_acc   = in_valid && in_ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_acc)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_word_reg <= in_word;
        end
        if (step)
        begin
            out_word_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule
